// ===== hdl/cleb_pkg.sv =====
// Shared types, constants and key decode for the cursor line edit buffer.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package cleb_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int IDX_W         = $clog2(LINE_CAPACITY);
    localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);

    localparam logic [7:0] KEY_END   = 8'h00;
    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_DEL   = 8'h2D;

    typedef enum logic [2:0] {
        KIND_END,
        KIND_LEFT,
        KIND_RIGHT,
        KIND_DEL,
        KIND_INS
    } key_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE_L,
        S_MOVE_R,
        S_FL_RD,
        S_FL_OUT,
        S_FL_EMPTY
    } state_t;

    // Commands from controller to datapath; at most one is active per cycle.
    typedef struct packed {
        logic do_ins;
        logic do_ovf;
        logic do_del;
        logic mv_rd_l;
        logic mv_rd_r;
        logic mv_wr_l;
        logic mv_wr_r;
        logic fl_start;
        logic fl_rd;
        logic fl_load;
        logic empty_load;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        key_kind_t        kind;
        logic             can_left;
        logic             can_right;
        logic             can_del;
        logic             full;
        logic             empty;
        logic             flush_last;
        logic             out_free;
        logic [CNT_W-1:0] total;
    } status_t;

    function automatic key_kind_t key_decode(input logic [7:0] key);
        key_kind_t kind;
        unique case (key)
            KEY_END:   kind = KIND_END;
            KEY_LEFT:  kind = KIND_LEFT;
            KEY_RIGHT: kind = KIND_RIGHT;
            KEY_DEL:   kind = KIND_DEL;
            default:   kind = KIND_INS;
        endcase
        return kind;
    endfunction

endpackage

// ===== hdl/cleb_ctrl.sv =====
// Controller state machine for the cursor line edit buffer.
// Depends on cleb_pkg (state, command and status types).
`timescale 1ns / 1ps

module cleb_ctrl
    import cleb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output logic    in_ready,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    logic accept;

    assign accept = in_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (status.kind)
                        KIND_END:
                        begin
                            state_next = status.empty ? S_FL_EMPTY : S_FL_RD;
                        end
                        KIND_LEFT:
                        begin
                            if (status.can_left)
                            begin
                                state_next = S_MOVE_L;
                            end
                        end
                        KIND_RIGHT:
                        begin
                            if (status.can_right)
                            begin
                                state_next = S_MOVE_R;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOVE_L, S_MOVE_R:
            begin
                state_next = S_IDLE;
            end
            S_FL_RD:
            begin
                state_next = S_FL_OUT;
            end
            S_FL_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = status.flush_last ? S_IDLE : S_FL_RD;
                end
            end
            S_FL_EMPTY:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    unique case (status.kind)
                        KIND_END:   cmd.fl_start = !status.empty;
                        KIND_LEFT:  cmd.mv_rd_l  = status.can_left;
                        KIND_RIGHT: cmd.mv_rd_r  = status.can_right;
                        KIND_DEL:   cmd.do_del   = status.can_del;
                        KIND_INS:
                        begin
                            cmd.do_ovf = status.full;
                            cmd.do_ins = !status.full;
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            S_MOVE_L:   cmd.mv_wr_l    = 1'b1;
            S_MOVE_R:   cmd.mv_wr_r    = 1'b1;
            S_FL_RD:    cmd.fl_rd      = 1'b1;
            S_FL_OUT:   cmd.fl_load    = status.out_free;
            S_FL_EMPTY: cmd.empty_load = status.out_free;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/cleb_datapath.sv =====
// Datapath for the cursor line edit buffer: both stack memories, counts,
// overflow flag, flush pointer and output register. Depends on cleb_pkg.
`timescale 1ns / 1ps

module cleb_datapath
    import cleb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic [7:0] key_byte,
    input  logic       out_ready,
    output status_t    status,
    output logic       out_valid,
    output logic [7:0] text_char,
    output logic       line_empty,
    output logic       last_char,
    output logic       overflowed
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    logic [7:0] left_mem  [LINE_CAPACITY];
    logic [7:0] right_mem [LINE_CAPACITY];

    logic [CNT_W-1:0] lc_reg, lc_next;
    logic [CNT_W-1:0] rc_reg, rc_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             ovf_reg, ovf_next;
    logic             from_left_reg;
    logic [7:0]       left_rdata_reg;
    logic [7:0]       right_rdata_reg;

    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_empty_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;

    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] pos_inc;
    logic [CNT_W-1:0] right_flush_idx;
    logic [IDX_W-1:0] left_rd_addr;
    logic [IDX_W-1:0] right_rd_addr;
    logic             clear_line;

    assign total           = lc_reg + rc_reg;
    assign pos_inc         = pos_reg + ONE;
    assign right_flush_idx = total - ONE - pos_reg;
    assign left_rd_addr    = cmd.mv_rd_l ? IDX_W'(lc_reg - ONE) : pos_reg[IDX_W-1:0];
    assign right_rd_addr   = cmd.mv_rd_r ? IDX_W'(rc_reg - ONE)
                                         : right_flush_idx[IDX_W-1:0];
    assign clear_line      = (cmd.fl_load && status.flush_last) || cmd.empty_load;

    assign status.kind       = key_decode(key_byte);
    assign status.can_left   = (lc_reg != '0) && (rc_reg < CAP);
    assign status.can_right  = (rc_reg != '0) && (lc_reg < CAP);
    assign status.can_del    = (lc_reg != '0);
    assign status.full       = (total >= CAP);
    assign status.empty      = (total == '0);
    assign status.flush_last = (pos_inc == total);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.total      = total;

    // Stack memories: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (cmd.do_ins)
        begin
            left_mem[lc_reg[IDX_W-1:0]] <= key_byte;
        end
        else if (cmd.mv_wr_r)
        begin
            left_mem[lc_reg[IDX_W-1:0]] <= right_rdata_reg;
        end
        if (cmd.mv_rd_l || cmd.fl_rd)
        begin
            left_rdata_reg <= left_mem[left_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mv_wr_l)
        begin
            right_mem[rc_reg[IDX_W-1:0]] <= left_rdata_reg;
        end
        if (cmd.mv_rd_r || cmd.fl_rd)
        begin
            right_rdata_reg <= right_mem[right_rd_addr];
        end
    end

    always_comb
    begin
        lc_next  = lc_reg;
        rc_next  = rc_reg;
        pos_next = pos_reg;
        ovf_next = ovf_reg;
        if (cmd.do_ins || cmd.mv_wr_r)
        begin
            lc_next = lc_reg + ONE;
        end
        if (cmd.do_del || cmd.mv_wr_l)
        begin
            lc_next = lc_reg - ONE;
        end
        if (cmd.mv_wr_l)
        begin
            rc_next = rc_reg + ONE;
        end
        if (cmd.mv_wr_r)
        begin
            rc_next = rc_reg - ONE;
        end
        if (cmd.do_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.fl_start)
        begin
            pos_next = '0;
        end
        if (cmd.fl_load)
        begin
            pos_next = pos_inc;
        end
        if (clear_line)
        begin
            lc_next  = '0;
            rc_next  = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg        <= '0;
            rc_reg        <= '0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lc_reg  <= lc_next;
            rc_reg  <= rc_next;
            pos_reg <= pos_next;
            ovf_reg <= ovf_next;
            if (cmd.fl_load || cmd.empty_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Flush source and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.fl_rd)
        begin
            from_left_reg <= (pos_reg < lc_reg);
        end
        if (cmd.fl_load)
        begin
            out_char_reg  <= from_left_reg ? left_rdata_reg : right_rdata_reg;
            out_empty_reg <= 1'b0;
            out_last_reg  <= status.flush_last;
            out_ovf_reg   <= ovf_reg;
        end
        else if (cmd.empty_load)
        begin
            out_char_reg  <= 8'h00;
            out_empty_reg <= 1'b1;
            out_last_reg  <= 1'b1;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign text_char  = out_char_reg;
    assign line_empty = out_empty_reg;
    assign last_char  = out_last_reg;
    assign overflowed = out_ovf_reg;

endmodule

// ===== hdl/cursor_line_edit_buffer_top.sv =====
// Top level of the cursor line edit buffer: controller plus datapath.
// Depends on cleb_pkg, cleb_ctrl and cleb_datapath.
//
//  Channel  | Direction | Payload
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tdata[7:0] key_byte
//  m_axis   | out       | tdata[7:0] text_char, tuser[0] line_empty,
//           |           | tuser[1] overflowed, tlast = last_char
//
// Steps: insert, delete and ignored keys are handled on their accept; a cursor
// move is a registered stack read, then a write to the other stack. A flush
// starts on its accept, then each character takes a read issue and then an
// output load, as the stack read is registered; an empty flush then loads the marker.
// Reset: asynchronous, active low; clears counts, flag and control. Stack
// memories are not cleared, so there is no clearing pass after reset.
// Stalls: a held m_axis_tready holds the flush; the output register lets a
// new key be taken while the last result of a flush is still waiting.
`timescale 1ns / 1ps

module cursor_line_edit_buffer_top
    import cleb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] key_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] text_char
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // [0] line_empty, [1] overflowed
);

    cmd_t    cmd;
    status_t status;

    // Sequence edits and flush walks
    cleb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    // Hold both stacks and drive the output transaction register
    cleb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key_byte   (s_axis_tdata),
        .out_ready  (m_axis_tready),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .text_char  (m_axis_tdata),
        .line_empty (m_axis_tuser[0]),
        .last_char  (m_axis_tlast),
        .overflowed (m_axis_tuser[1])
    );

    // The line never holds more characters than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        status.total <= CNT_W'(LINE_CAPACITY))
        else $error("line length exceeds capacity");

    // At most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("conflicting datapath commands");

    // Loading the final character of a flush, or the empty marker, empties the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fl_load && status.flush_last) || cmd.empty_load |=> status.total == '0)
        else $error("line not cleared after flush");

    // The empty marker is only sent for an empty line
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.empty_load |-> status.empty)
        else $error("empty marker for a non-empty line");

endmodule
